[hdl/ultrasonic_echo_ranger_assert.svh]
// Assertion macros for the checker file of the echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define UER_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("echo ranger assertion failed");

// Checked at every clock edge, reset included.
`define UER_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("echo ranger assertion failed");

`endif

[hdl/uer_pkg.sv]
`default_nettype none
package uer_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 20;

   localparam int TIMEOUT_W = 20;
   localparam int TRIGGER_W = 8;
   localparam int HOLDOFF_W = 20;
   localparam int PULSE_W   = 20;
   localparam int CM_W      = 19;
   localparam int INCH_W    = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd30000;
   localparam logic [TRIGGER_W-1:0] TRIGGER_RESET = 8'd10;
   localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 20'd100000;

   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF = 2'd2;

   // Reciprocals of 29 and 37 scaled by 2**32; exact for the operand range used.
   localparam int RECIP_SHIFT  = 32;
   localparam int CM_RECIP_W   = 28;
   localparam int INCH_RECIP_W = 27;
   localparam logic [CM_RECIP_W-1:0]   CM_RECIP   = 28'd148102321;
   localparam logic [INCH_RECIP_W-1:0] INCH_RECIP = 27'd116080198;

   typedef enum logic [5:0] {
      PH_IDLE      = 6'b000001,
      PH_WAIT_LOW  = 6'b000010,
      PH_TRIG      = 6'b000100,
      PH_WAIT_HIGH = 6'b001000,
      PH_COUNT     = 6'b010000,
      PH_HOLDOFF   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [TRIGGER_W-1:0] trigger_ticks;
      logic [HOLDOFF_W-1:0] holdoff_ticks;
   } cfg_type;

   typedef struct packed {
      logic [INCH_W-1:0]  distance_inch_q4;
      logic [CM_W-1:0]    distance_cm_q4;
      logic [PULSE_W-1:0] pulse_ticks;
      logic               failed;
      logic               done_res;
      logic               busy_res;
      logic               trigger_out;
   } rsp_type;

endpackage
`default_nettype wire

[hdl/ultrasonic_echo_ranger.sv]
// The result word for a tick is registered in the output stage when the tick word is accepted.
// Throughput: one tick word per cycle while req_tready is high, as the phase machine updates on each accepted word.
// A two-entry output stage keeps req_tready high until two results wait untaken.
// Reset is synchronous: the phase machine goes idle, counters and held results clear,
// and the three registers return to timeout 30000, trigger 10 and holdoff 100000.
`default_nettype none
module ultrasonic_echo_ranger #(
   parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: start_req, echo_level, zero fill.
   input  wire logic [7:0]                     req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // Fields from bit 0: trigger_out, busy_res, failed, pulse_ticks,
   // distance_cm_q4, distance_inch_q4, zero fill.
   output logic [63:0]                         rsp_tdata,
   // Carries done_res, the last word of a measurement.
   output logic                                rsp_tlast,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [uer_pkg::CSR_DAT_W-1:0] csr_data
);

   uer_pkg::cfg_type cfg;
   uer_pkg::rsp_type core_rsp;
   uer_pkg::rsp_type out_rsp;
   logic             accept;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid & req_tready;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   uer_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .start_req  (req_tdata[0]),
      .echo_level (req_tdata[1]),
      .cfg        (cfg),
      .rsp        (core_rsp)
   );

   uer_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (core_rsp),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_rsp)
   );

   assign rsp_tdata = {5'b00000,
                       out_rsp.distance_inch_q4,
                       out_rsp.distance_cm_q4,
                       out_rsp.pulse_ticks,
                       out_rsp.failed,
                       out_rsp.busy_res,
                       out_rsp.trigger_out};
   assign rsp_tlast = out_rsp.done_res;

endmodule
`default_nettype wire

[hdl/uer_csr.sv]
`default_nettype none
module uer_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [uer_pkg::CSR_DAT_W-1:0] csr_data,
   output uer_pkg::cfg_type                    cfg
);

   uer_pkg::cfg_type cfg_ff;
   uer_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            uer_pkg::REG_TIMEOUT: begin
               cfg_in.timeout_ticks = csr_data[uer_pkg::TIMEOUT_W-1:0];
            end
            uer_pkg::REG_TRIGGER: begin
               cfg_in.trigger_ticks = csr_data[uer_pkg::TRIGGER_W-1:0];
            end
            uer_pkg::REG_HOLDOFF: begin
               cfg_in.holdoff_ticks = csr_data[uer_pkg::HOLDOFF_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= uer_pkg::TIMEOUT_RESET;
         cfg_ff.trigger_ticks <= uer_pkg::TRIGGER_RESET;
         cfg_ff.holdoff_ticks <= uer_pkg::HOLDOFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[hdl/uer_scale.sv]
`default_nettype none
module uer_scale (
   input  wire logic [uer_pkg::PULSE_W-1:0] pulse,
   output logic [uer_pkg::CM_W-1:0]         distance_cm_q4,
   output logic [uer_pkg::INCH_W-1:0]       distance_inch_q4
);

   // cm = 16*p/58 = 8*p/29, inch = 16*p/148 = 4*p/37.
   localparam int CM_X_W     = uer_pkg::PULSE_W + 3;
   localparam int INCH_X_W   = uer_pkg::PULSE_W + 2;
   localparam int CM_PROD_W   = CM_X_W + uer_pkg::CM_RECIP_W;
   localparam int INCH_PROD_W = INCH_X_W + uer_pkg::INCH_RECIP_W;

   logic [CM_X_W-1:0]      cm_x;
   logic [INCH_X_W-1:0]    inch_x;
   logic [CM_PROD_W-1:0]   cm_prod;
   logic [INCH_PROD_W-1:0] inch_prod;

   assign cm_x      = {pulse, 3'b000};
   assign inch_x    = {pulse, 2'b00};
   assign cm_prod   = CM_PROD_W'(cm_x) * CM_PROD_W'(uer_pkg::CM_RECIP);
   assign inch_prod = INCH_PROD_W'(inch_x) * INCH_PROD_W'(uer_pkg::INCH_RECIP);

   assign distance_cm_q4 =
      cm_prod[uer_pkg::RECIP_SHIFT +: uer_pkg::CM_W];
   assign distance_inch_q4 =
      inch_prod[uer_pkg::RECIP_SHIFT +: uer_pkg::INCH_W];

endmodule
`default_nettype wire

[hdl/uer_core.sv]
`default_nettype none
module uer_core #(
   parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       start_req,
   input  wire logic       echo_level,
   input  uer_pkg::cfg_type cfg,
   output uer_pkg::rsp_type rsp
);

   localparam int CMPW = (COUNT_WIDTH > uer_pkg::PULSE_W) ? COUNT_WIDTH : uer_pkg::PULSE_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   uer_pkg::phase_type phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]      tick_count_ff, tick_count_in;
   logic [COUNT_WIDTH-1:0]      held_ff, held_in;
   logic [uer_pkg::CM_W-1:0]    cm_ff, cm_in;
   logic [uer_pkg::INCH_W-1:0]  inch_ff, inch_in;
   logic                        last_ok_ff, last_ok_in;

   logic [CMPW-1:0]             count_ext;
   logic [CMPW-1:0]             timeout_ext;
   logic [CMPW-1:0]             held_ext;
   logic [COUNT_WIDTH-1:0]      count_inc;
   logic [COUNT_WIDTH-1:0]      high_base;
   logic                        wait_expired;
   logic                        high_expired;
   logic                        holdoff_end;
   logic [uer_pkg::CM_W-1:0]    scale_cm;
   logic [uer_pkg::INCH_W-1:0]  scale_inch;
   logic                        trig, busy, done, err, capture;

   assign count_ext    = CMPW'(tick_count_ff);
   assign timeout_ext  = CMPW'(cfg.timeout_ticks);
   assign count_inc    = COUNT_WIDTH'(tick_count_ff + 1'b1);
   assign wait_expired = (count_ext >= timeout_ext) || (tick_count_ff == CNT_MAX);
   // When the echo rises during the wait, the first counted tick starts from zero.
   assign high_base    = echo_level ? '0 : tick_count_ff;
   assign high_expired = (CMPW'(high_base) >= timeout_ext) || (high_base == CNT_MAX);
   assign holdoff_end  = (CMPW'(count_inc) >= CMPW'(cfg.holdoff_ticks)) ||
                         (count_inc == CNT_MAX);

   uer_scale u_scale (
      .pulse            (count_ext[uer_pkg::PULSE_W-1:0]),
      .distance_cm_q4   (scale_cm),
      .distance_inch_q4 (scale_inch)
   );

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      trig          = 1'b0;
      busy          = 1'b1;
      done          = 1'b0;
      err           = 1'b0;
      capture       = 1'b0;
      case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (start_req) begin
               phase_in      = uer_pkg::PH_WAIT_LOW;
               tick_count_in = '0;
            end else begin
               busy = 1'b0;
            end
         end
         uer_pkg::PH_WAIT_LOW: begin
            if (!echo_level) begin
               phase_in      = uer_pkg::PH_TRIG;
               tick_count_in = COUNT_WIDTH'(1);
               trig          = 1'b1;
            end else if (wait_expired) begin
               err = 1'b1;
            end else begin
               tick_count_in = count_inc;
            end
         end
         uer_pkg::PH_TRIG: begin
            if (count_ext >= CMPW'(cfg.trigger_ticks)) begin
               phase_in      = uer_pkg::PH_WAIT_HIGH;
               tick_count_in = '0;
            end else begin
               tick_count_in = count_inc;
               trig          = 1'b1;
            end
         end
         uer_pkg::PH_WAIT_HIGH: begin
            if (echo_level) begin
               phase_in = uer_pkg::PH_COUNT;
            end
            if (high_expired) begin
               err = 1'b1;
            end else begin
               tick_count_in = COUNT_WIDTH'(high_base + 1'b1);
            end
         end
         uer_pkg::PH_COUNT: begin
            if (echo_level) begin
               if (wait_expired) begin
                  err = 1'b1;
               end else begin
                  tick_count_in = count_inc;
               end
            end else begin
               capture       = 1'b1;
               done          = 1'b1;
               tick_count_in = '0;
               phase_in      = (cfg.holdoff_ticks == '0) ? uer_pkg::PH_IDLE
                                                         : uer_pkg::PH_HOLDOFF;
            end
         end
         uer_pkg::PH_HOLDOFF: begin
            tick_count_in = count_inc;
            if (holdoff_end) begin
               phase_in      = uer_pkg::PH_IDLE;
               tick_count_in = '0;
            end
         end
         default: begin
            phase_in      = uer_pkg::PH_IDLE;
            tick_count_in = '0;
            busy          = 1'b0;
         end
      endcase
      if (err) begin
         done          = 1'b1;
         phase_in      = uer_pkg::PH_IDLE;
         tick_count_in = '0;
      end
   end

   assign held_in    = capture ? tick_count_ff : held_ff;
   assign cm_in      = capture ? scale_cm : cm_ff;
   assign inch_in    = capture ? scale_inch : inch_ff;
   assign last_ok_in = capture | (last_ok_ff & ~err);
   assign held_ext   = CMPW'(held_in);

   always_comb begin
      rsp.trigger_out      = trig;
      rsp.busy_res         = busy;
      rsp.done_res         = done;
      rsp.failed           = err;
      rsp.pulse_ticks      = held_ext[uer_pkg::PULSE_W-1:0];
      rsp.distance_cm_q4   = last_ok_in ? cm_in : '0;
      rsp.distance_inch_q4 = last_ok_in ? inch_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= uer_pkg::PH_IDLE;
         tick_count_ff <= '0;
         held_ff       <= '0;
         cm_ff         <= '0;
         inch_ff       <= '0;
         last_ok_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         held_ff       <= held_in;
         cm_ff         <= cm_in;
         inch_ff       <= inch_in;
         last_ok_ff    <= last_ok_in;
      end
   end

endmodule
`default_nettype wire

[hdl/uer_skid.sv]
`default_nettype none
module uer_skid (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  uer_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             out_valid,
   input  wire logic        out_ready,
   output uer_pkg::rsp_type out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   uer_pkg::rsp_type out_data_ff, out_data_in;
   uer_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             pop;

   assign pop = out_valid_ff & out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in = push_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign push_ready = ~skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

endmodule
`default_nettype wire

[hdl/uer_checker.sv]
`default_nettype none
`include "ultrasonic_echo_ranger_assert.svh"
module uer_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [7:0]                     req_tdata,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [63:0]                    rsp_tdata,
   input wire logic                           rsp_tlast,
   input wire logic                           csr_valid,
   input wire logic                           csr_ready,
   input wire logic [uer_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [uer_pkg::CSR_DAT_W-1:0] csr_data
);

   logic unused_ok;
   assign unused_ok = &{1'b0, req_tvalid, req_tready, req_tdata, csr_valid, csr_ready,
                        csr_index, csr_data};

   // A stalled result word holds.
   `UER_ASSERT(held_rsp_a, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   // A timeout flag only comes with the end of a measurement.
   `UER_ASSERT(fail_done_a, rsp_tvalid && rsp_tdata[2] |-> rsp_tlast)
   // A failed measurement reports zero distances.
   `UER_ASSERT(fail_zero_a, rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[58:23] == 36'd0)
   // Trigger and done are only seen while the ranger is busy.
   `UER_ASSERT(busy_a, rsp_tvalid && (rsp_tdata[0] || rsp_tlast) |-> rsp_tdata[1])
   // No result word is offered right after reset.
   `UER_ASSERT_ALWAYS(reset_a, $past(reset) |-> !rsp_tvalid)

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (.*);
`default_nettype wire
